// File: sv/onl_pkg.sv
// Shared types and character constants for the object notation tokenizer.
`default_nettype none

package onl_pkg;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'd0,
        MODE_SLASH   = 4'd1,
        MODE_COMMENT = 4'd2,
        MODE_STRING  = 4'd3,
        MODE_ESCAPE  = 4'd4,
        MODE_IDENT   = 4'd5,
        MODE_ZERO    = 4'd6,
        MODE_BIN     = 4'd7,
        MODE_OCT     = 4'd8,
        MODE_HEX     = 4'd9,
        MODE_DEC     = 4'd10,
        MODE_DONE    = 4'd11,
        MODE_ERROR   = 4'd12
    } t_mode;

    localparam logic [3:0] TT_DOT    = 4'd0;
    localparam logic [3:0] TT_LBRACE = 4'd1;
    localparam logic [3:0] TT_RBRACE = 4'd2;
    localparam logic [3:0] TT_EQUALS = 4'd3;
    localparam logic [3:0] TT_COMMA  = 4'd4;
    localparam logic [3:0] TT_STRING = 4'd5;
    localparam logic [3:0] TT_IDENT  = 4'd6;
    localparam logic [3:0] TT_BIN    = 4'd7;
    localparam logic [3:0] TT_OCT    = 4'd8;
    localparam logic [3:0] TT_HEX    = 4'd9;
    localparam logic [3:0] TT_INT    = 4'd10;

    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_O  = 8'h6F;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // One result beat.
    typedef struct packed {
        logic [3:0] token_type;
        logic       has_char;
        logic [7:0] char_value;
        logic       token_first;
        logic       token_last;
        logic       finished;
        logic       error_flag;
        logic       run_last;
    } t_res;

    // All beats caused by one input item; dual marks that r1 is used too.
    typedef struct packed {
        logic dual;
        t_res r0;
        t_res r1;
    } t_bundle;

endpackage

`default_nettype wire

// File: sv/onl_front.sv
// Front end: lexer state machine that turns one input item into a bundle of beats.
`default_nettype none

module onl_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic            i_kind,
    input  wire logic [7:0]      i_byte,
    input  wire logic [15:0]     i_limit,
    output logic                 o_push,
    output onl_pkg::t_bundle     o_bundle
);

    typedef struct packed {
        logic           put;
        logic           punct;
        onl_pkg::t_res  res;
        onl_pkg::t_mode mode;
    } t_start;

    function automatic onl_pkg::t_res mk_res(logic [3:0] tt, logic has, logic [7:0] ch,
                                             logic first, logic last);
        onl_pkg::t_res r;
        r = '0;
        r.token_type  = tt;
        r.has_char    = has;
        r.char_value  = ch;
        r.token_first = first;
        r.token_last  = last;
        return r;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic [3:0] mode_type(onl_pkg::t_mode m);
        case (m)
            onl_pkg::MODE_STRING, onl_pkg::MODE_ESCAPE: return onl_pkg::TT_STRING;
            onl_pkg::MODE_IDENT: return onl_pkg::TT_IDENT;
            onl_pkg::MODE_BIN:   return onl_pkg::TT_BIN;
            onl_pkg::MODE_OCT:   return onl_pkg::TT_OCT;
            onl_pkg::MODE_HEX:   return onl_pkg::TT_HEX;
            default:             return onl_pkg::TT_INT;
        endcase
    endfunction

    function automatic logic continues(onl_pkg::t_mode m, logic [7:0] c);
        case (m)
            onl_pkg::MODE_IDENT: return is_alpha(c) || is_digit(c) || c == onl_pkg::CH_UNDER;
            onl_pkg::MODE_BIN:   return c inside {8'h30, 8'h31, 8'h5F};
            onl_pkg::MODE_OCT:   return c inside {[8'h30:8'h37]};
            onl_pkg::MODE_HEX:   return is_digit(c) || (c inside {[8'h61:8'h66]})
                                        || (c inside {[8'h41:8'h46]});
            default:             return is_digit(c);
        endcase
    endfunction

    // What a byte does when no token is open.
    function automatic t_start start_dec(logic [7:0] c);
        t_start s;
        s = '0;
        s.mode = onl_pkg::MODE_IDLE;
        case (c)
            onl_pkg::CH_DOT: begin
                s.put = 1'b1; s.punct = 1'b1; s.res = mk_res(onl_pkg::TT_DOT, 1'b1, c, 1'b1, 1'b1);
            end
            onl_pkg::CH_LBRACE: begin
                s.put = 1'b1; s.punct = 1'b1;
                s.res = mk_res(onl_pkg::TT_LBRACE, 1'b1, c, 1'b1, 1'b1);
            end
            onl_pkg::CH_RBRACE: begin
                s.put = 1'b1; s.punct = 1'b1;
                s.res = mk_res(onl_pkg::TT_RBRACE, 1'b1, c, 1'b1, 1'b1);
            end
            onl_pkg::CH_EQUALS: begin
                s.put = 1'b1; s.punct = 1'b1;
                s.res = mk_res(onl_pkg::TT_EQUALS, 1'b1, c, 1'b1, 1'b1);
            end
            onl_pkg::CH_COMMA: begin
                s.put = 1'b1; s.punct = 1'b1;
                s.res = mk_res(onl_pkg::TT_COMMA, 1'b1, c, 1'b1, 1'b1);
            end
            onl_pkg::CH_QUOTE: begin
                s.put = 1'b1; s.mode = onl_pkg::MODE_STRING;
                s.res = mk_res(onl_pkg::TT_STRING, 1'b0, 8'd0, 1'b1, 1'b0);
            end
            onl_pkg::CH_ZERO: begin
                s.mode = onl_pkg::MODE_ZERO;
            end
            onl_pkg::CH_SLASH: begin
                s.mode = onl_pkg::MODE_SLASH;
            end
            default: begin
                if (is_alpha(c) || c == onl_pkg::CH_UNDER) begin
                    s.put = 1'b1; s.mode = onl_pkg::MODE_IDENT;
                    s.res = mk_res(onl_pkg::TT_IDENT, 1'b1, c, 1'b1, 1'b0);
                end else if (c inside {[8'h31:8'h39]}) begin
                    s.put = 1'b1; s.mode = onl_pkg::MODE_DEC;
                    s.res = mk_res(onl_pkg::TT_INT, 1'b1, c, 1'b1, 1'b0);
                end
            end
        endcase
        return s;
    endfunction

    function automatic logic [15:0] sat_inc(logic [15:0] v);
        return (v == onl_pkg::COUNT_MAX) ? v : v + 16'd1;
    endfunction

    onl_pkg::t_mode r_mode, n_mode;
    logic [15:0]    r_count, n_count;

    t_start         v_st;
    onl_pkg::t_res  v_r0, v_r1, v_err;
    logic [1:0]     v_n;
    logic [15:0]    v_inc1, v_inc2;
    logic           v_hit1, v_hit2;
    logic [3:0]     v_tt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= onl_pkg::MODE_IDLE;
            r_count <= 16'd0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    always_comb begin
        v_st   = start_dec(i_byte);
        v_inc1 = sat_inc(r_count);
        v_inc2 = sat_inc(v_inc1);
        v_hit1 = v_inc1 >= i_limit;
        v_hit2 = v_inc2 >= i_limit;
        v_tt   = mode_type(r_mode);
        v_err  = '0;
        v_err.error_flag = 1'b1;
        v_r0    = '0;
        v_r1    = '0;
        v_n     = 2'd0;
        n_mode  = r_mode;
        n_count = r_count;

        if (i_kind) begin
            case (r_mode)
                onl_pkg::MODE_IDLE, onl_pkg::MODE_COMMENT: begin
                    v_r0.finished = 1'b1;
                    v_n = 2'd1;
                    n_mode = onl_pkg::MODE_DONE;
                end
                onl_pkg::MODE_SLASH, onl_pkg::MODE_ZERO: begin
                    v_r0 = v_err;
                    v_n = 2'd1;
                    n_mode = onl_pkg::MODE_ERROR;
                end
                onl_pkg::MODE_DONE, onl_pkg::MODE_ERROR: begin
                    n_mode = r_mode;
                end
                default: begin
                    // An open token is closed and the run ends successfully.
                    v_r0 = mk_res(v_tt, 1'b0, 8'd0, 1'b0, 1'b1);
                    v_r0.finished = 1'b1;
                    v_n = 2'd1;
                    n_count = v_inc1;
                    n_mode = onl_pkg::MODE_DONE;
                end
            endcase
        end else begin
            case (r_mode)
                onl_pkg::MODE_IDLE: begin
                    n_mode = v_st.mode;
                    if (v_st.put) begin
                        v_r0 = v_st.res;
                        v_n = 2'd1;
                    end
                    if (v_st.punct) begin
                        n_count = v_inc1;
                        if (v_hit1) begin
                            v_r0.finished = 1'b1;
                            n_mode = onl_pkg::MODE_DONE;
                        end
                    end
                end
                onl_pkg::MODE_SLASH: begin
                    if (i_byte == onl_pkg::CH_SLASH) begin
                        n_mode = onl_pkg::MODE_COMMENT;
                    end else begin
                        v_r0 = v_err;
                        v_n = 2'd1;
                        n_mode = onl_pkg::MODE_ERROR;
                    end
                end
                onl_pkg::MODE_COMMENT: begin
                    if (i_byte == onl_pkg::CH_NL) begin
                        n_mode = onl_pkg::MODE_IDLE;
                    end
                end
                onl_pkg::MODE_STRING: begin
                    v_n = 2'd1;
                    if (i_byte == onl_pkg::CH_QUOTE) begin
                        v_r0 = mk_res(onl_pkg::TT_STRING, 1'b0, 8'd0, 1'b0, 1'b1);
                        n_count = v_inc1;
                        n_mode = onl_pkg::MODE_IDLE;
                        if (v_hit1) begin
                            v_r0.finished = 1'b1;
                            n_mode = onl_pkg::MODE_DONE;
                        end
                    end else begin
                        v_r0 = mk_res(onl_pkg::TT_STRING, 1'b1, i_byte, 1'b0, 1'b0);
                        if (i_byte == onl_pkg::CH_BSLASH) begin
                            n_mode = onl_pkg::MODE_ESCAPE;
                        end
                    end
                end
                onl_pkg::MODE_ESCAPE: begin
                    v_r0 = mk_res(onl_pkg::TT_STRING, 1'b1, i_byte, 1'b0, 1'b0);
                    v_n = 2'd1;
                    n_mode = onl_pkg::MODE_STRING;
                end
                onl_pkg::MODE_ZERO: begin
                    if (i_byte == onl_pkg::CH_LOW_B) begin
                        v_r0 = mk_res(onl_pkg::TT_BIN, 1'b1, onl_pkg::CH_ZERO, 1'b1, 1'b0);
                        v_r1 = mk_res(onl_pkg::TT_BIN, 1'b1, i_byte, 1'b0, 1'b0);
                        v_n = 2'd2;
                        n_mode = onl_pkg::MODE_BIN;
                    end else if (i_byte == onl_pkg::CH_LOW_O) begin
                        v_r0 = mk_res(onl_pkg::TT_OCT, 1'b1, onl_pkg::CH_ZERO, 1'b1, 1'b0);
                        v_r1 = mk_res(onl_pkg::TT_OCT, 1'b1, i_byte, 1'b0, 1'b0);
                        v_n = 2'd2;
                        n_mode = onl_pkg::MODE_OCT;
                    end else if (i_byte == onl_pkg::CH_LOW_X) begin
                        v_r0 = mk_res(onl_pkg::TT_HEX, 1'b1, onl_pkg::CH_ZERO, 1'b1, 1'b0);
                        v_r1 = mk_res(onl_pkg::TT_HEX, 1'b1, i_byte, 1'b0, 1'b0);
                        v_n = 2'd2;
                        n_mode = onl_pkg::MODE_HEX;
                    end else begin
                        v_r0 = v_err;
                        v_n = 2'd1;
                        n_mode = onl_pkg::MODE_ERROR;
                    end
                end
                onl_pkg::MODE_IDENT, onl_pkg::MODE_BIN, onl_pkg::MODE_OCT,
                onl_pkg::MODE_HEX, onl_pkg::MODE_DEC: begin
                    v_n = 2'd1;
                    if (continues(r_mode, i_byte)) begin
                        v_r0 = mk_res(v_tt, 1'b1, i_byte, 1'b0, 1'b0);
                    end else begin
                        // Close the token, then, unless the limit is reached, look at the same byte afresh.
                        v_r0 = mk_res(v_tt, 1'b0, 8'd0, 1'b0, 1'b1);
                        n_count = v_inc1;
                        if (v_hit1) begin
                            v_r0.finished = 1'b1;
                            n_mode = onl_pkg::MODE_DONE;
                        end else begin
                            n_mode = v_st.mode;
                            if (v_st.put) begin
                                v_r1 = v_st.res;
                                v_n = 2'd2;
                            end
                            if (v_st.punct) begin
                                n_count = v_inc2;
                                if (v_hit2) begin
                                    v_r1.finished = 1'b1;
                                    n_mode = onl_pkg::MODE_DONE;
                                end
                            end
                        end
                    end
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end

        if (v_n == 2'd2) begin
            v_r1.run_last = 1'b1;
        end else begin
            v_r0.run_last = 1'b1;
        end
    end

    assign o_push   = i_accept && (v_n != 2'd0);
    assign o_bundle = {(v_n == 2'd2), v_r0, v_r1};

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == onl_pkg::MODE_DONE) |=> (r_mode == onl_pkg::MODE_DONE))
        else $error("finished state left without reset");

    a_stopped_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_mode == onl_pkg::MODE_DONE) || (r_mode == onl_pkg::MODE_ERROR)) |-> !o_push)
        else $error("beats produced after the run stopped");

endmodule

`default_nettype wire

// File: sv/onl_fifo.sv
// Short bundle queue between the lexer front end and the beat serializer.
`default_nettype none

module onl_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire onl_pkg::t_bundle i_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output onl_pkg::t_bundle      o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    onl_pkg::t_bundle r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("queue fill count beyond depth");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_cnt == $past(r_cnt) - 1'b1) || !$past(i_rst_n))
        else $error("queue count did not drop on a lone pop");

endmodule

`default_nettype wire

// File: sv/onl_back.sv
// Back end: walks the beats of the bundle at the queue head onto the result ports.
`default_nettype none

module onl_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire onl_pkg::t_bundle i_head,
    input  wire logic             i_q_empty,
    input  wire logic             i_pop,
    output logic                  o_q_pop,
    output logic                  o_empty,
    output onl_pkg::t_res         o_res
);

    logic r_sel, n_sel;
    logic beat;

    assign o_empty = i_q_empty;
    assign beat    = i_pop && !i_q_empty;
    assign o_res   = r_sel ? i_head.r1 : i_head.r0;
    assign o_q_pop = beat && (r_sel || !i_head.dual);

    always_comb begin
        n_sel = r_sel;
        if (beat) begin
            n_sel = !r_sel && i_head.dual;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else begin
            r_sel <= n_sel;
        end
    end

    a_sel_dual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> (!i_q_empty && i_head.dual))
        else $error("second beat selected without a two-beat bundle");

endmodule

`default_nettype wire

// File: sv/object_notation_tokenizer_unit.sv
// Top level of the object notation tokenizer: register port, lexer, queue and serializer.
// With nothing queued ahead, a beat is on the result ports right after the edge that
// accepts its byte. One byte is taken per cycle; input stalls only when the QUEUE_DEPTH
// queue is full. The output side moves one beat per cycle while pop is high and the queue
// is not empty, so a byte that yields two beats needs a pop for each.
// Reset (synchronous, active low) clears the lexer state, count and queue; limit becomes 255.
`default_nettype none

module object_notation_tokenizer_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Input queue side
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_byte_value,
    // Result queue side
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       o_token_type,
    output logic             o_has_char,
    output logic [7:0]       o_char_value,
    output logic             o_token_first,
    output logic             o_token_last,
    output logic             o_finished,
    output logic             o_error_flag,
    output logic             o_run_last
);

    localparam logic [15:0] LIMIT_RESET = 16'd255;

    logic [15:0]       r_token_limit, n_token_limit;
    logic              cfg_wr;
    logic              accept;
    logic              f_push;
    onl_pkg::t_bundle  f_bundle;
    onl_pkg::t_bundle  q_head;
    logic              q_full, q_empty, q_pop;
    onl_pkg::t_res     res;

    // The single register, token_limit, sits at byte address 0. Writes elsewhere are
    // acknowledged and dropped.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
    assign prdata = (paddr == 3'd0) ? {16'd0, r_token_limit} : 32'd0;

    always_comb begin
        n_token_limit = r_token_limit;
        if (cfg_wr) begin
            n_token_limit = pwdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_limit <= LIMIT_RESET;
        end else begin
            r_token_limit <= n_token_limit;
        end
    end

    // A byte is taken whenever the bundle queue has room, even if an earlier beat is
    // still waiting on the result side.
    assign full   = q_full;
    assign accept = push && !q_full;

    onl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_kind   (i_kind),
        .i_byte   (i_byte_value),
        .i_limit  (r_token_limit),
        .o_push   (f_push),
        .o_bundle (f_bundle)
    );

    onl_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_bundle),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // The serializer picks one of the two beats of the bundle at the queue head, which the read
    // pointer selects from storage, so a read select and a two-way select feed the result ports.
    onl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_empty (q_empty),
        .i_pop     (pop),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    assign o_token_type  = res.token_type;
    assign o_has_char    = res.has_char;
    assign o_char_value  = res.char_value;
    assign o_token_first = res.token_first;
    assign o_token_last  = res.token_last;
    assign o_finished    = res.finished;
    assign o_error_flag  = res.error_flag;
    assign o_run_last    = res.run_last;

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the object notation tokenizer: byte streams against a predictor.
`timescale 1ns / 100ps

module testbench;

    localparam int CLOCK_HALF    = 2;
    localparam int RESET_CYCLES  = 9;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_BEATS     = 3;
    localparam int PRINT_CAP     = 40;

    // The only register, token_limit, is register 0 and sits at byte address 0.
    localparam logic [2:0] LIMIT_ADDR = 3'd0;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // A beat that only reports finished or an error carries type 0 and no character.
    localparam logic [3:0] STATUS_TYPE = onl_pkg::TT_DOT;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_ONE   = 8'h31;

    // How the single stream is brought to a stop at the end of the run.
    typedef enum int {
        END_IDLE,
        END_COMMENT,
        END_IN_TOKEN,
        END_SLASH,
        END_ZERO,
        END_LIMIT
    } t_ending;

    // One input item: a text byte or the end-of-input marker.
    typedef struct packed {
        logic       kind;
        logic [7:0] value;
    } t_text_item;

    // Clock, reset and everything driven into the block start at known values.
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push         = 1'b0;
    logic        full;
    logic        i_kind       = KIND_DATA;
    logic [7:0]  i_byte_value = '0;
    logic        empty;
    logic        pop          = 1'b0;
    logic [3:0]  o_token_type;
    logic        o_has_char;
    logic [7:0]  o_char_value;
    logic        o_token_first;
    logic        o_token_last;
    logic        o_finished;
    logic        o_error_flag;
    logic        o_run_last;

    // Predictor state: our own copy of the lexer mode, the token count and the limit.
    onl_pkg::t_mode scan_mode   = onl_pkg::MODE_IDLE;
    logic [15:0]    token_total = '0;
    logic [15:0]    limit_copy  = 16'd255;

    // Beats caused by the item being predicted, then the store of beats still owed by the block.
    onl_pkg::t_res  item_beats [MAX_BEATS];
    int             item_count  = 0;
    onl_pkg::t_res  beats_due [$];

    // Text waiting to be pushed, filled by the stimulus process and drained by the driver.
    t_text_item  text_pending [$];
    t_text_item  next_item;

    int          send_gap    = 0;
    int          pop_gap     = 0;
    int          idle_odds   = 0;
    int          fail_count  = 0;
    int          cycle_count = 0;

    object_notation_tokenizer_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .i_kind        (i_kind),
        .i_byte_value  (i_byte_value),
        .empty         (empty),
        .pop           (pop),
        .o_token_type  (o_token_type),
        .o_has_char    (o_has_char),
        .o_char_value  (o_char_value),
        .o_token_first (o_token_first),
        .o_token_last  (o_token_last),
        .o_finished    (o_finished),
        .o_error_flag  (o_error_flag),
        .o_run_last    (o_run_last)
    );

    initial begin
        forever #(CLOCK_HALF) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------

    // Appends one beat for the current item; the block never makes more than two.
    function automatic void add_beat(input logic [3:0] tt, input logic has, input logic [7:0] ch,
                                     input logic first, input logic last);
        onl_pkg::t_res b;
        if (item_count < MAX_BEATS) begin
            b = '0;
            b.token_type  = tt;
            b.has_char    = has;
            b.char_value  = ch;
            b.token_first = first;
            b.token_last  = last;
            item_beats[item_count] = b;
            item_count++;
        end
    endfunction

    function automatic void flag_finished();
        if (item_count > 0) item_beats[item_count - 1].finished = 1'b1;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CH_LOW_A && c <= CH_LOW_A + 8'd25) || (c >= CH_UP_A && c <= CH_UP_A + 8'd25);
    endfunction

    function automatic logic is_dec_digit(input logic [7:0] c);
        return c >= onl_pkg::CH_ZERO && c <= onl_pkg::CH_ZERO + 8'd9;
    endfunction

    // Counting a finished token may hit the limit, which ends tokenizing with success.
    function automatic logic count_token();
        if (token_total != onl_pkg::COUNT_MAX) token_total++;
        if (token_total >= limit_copy) begin
            flag_finished();
            scan_mode = onl_pkg::MODE_DONE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic close_token(input logic [3:0] tt);
        add_beat(tt, 1'b0, 8'd0, 1'b0, 1'b1);
        scan_mode = onl_pkg::MODE_IDLE;
        return count_token();
    endfunction

    function automatic logic [3:0] mode_token_type(input onl_pkg::t_mode m);
        case (m)
            onl_pkg::MODE_STRING, onl_pkg::MODE_ESCAPE: return onl_pkg::TT_STRING;
            onl_pkg::MODE_IDENT:                        return onl_pkg::TT_IDENT;
            onl_pkg::MODE_BIN:                          return onl_pkg::TT_BIN;
            onl_pkg::MODE_OCT:                          return onl_pkg::TT_OCT;
            onl_pkg::MODE_HEX:                          return onl_pkg::TT_HEX;
            default:                                    return onl_pkg::TT_INT;
        endcase
    endfunction

    // Whether byte c keeps an identifier or a number of the given kind going.
    function automatic logic extends_token(input onl_pkg::t_mode m, input logic [7:0] c);
        case (m)
            onl_pkg::MODE_IDENT:
                return is_letter(c) || is_dec_digit(c) || c == onl_pkg::CH_UNDER;
            onl_pkg::MODE_BIN:
                return c == onl_pkg::CH_ZERO || c == CH_ONE || c == onl_pkg::CH_UNDER;
            onl_pkg::MODE_OCT:
                return c >= onl_pkg::CH_ZERO && c <= onl_pkg::CH_ZERO + 8'd7;
            onl_pkg::MODE_HEX:
                return is_dec_digit(c) || (c >= CH_LOW_A && c <= CH_LOW_A + 8'd5)
                       || (c >= CH_UP_A && c <= CH_UP_A + 8'd5);
            default:
                return is_dec_digit(c);
        endcase
    endfunction

    function automatic void emit_punct(input logic [3:0] tt, input logic [7:0] c);
        add_beat(tt, 1'b1, c, 1'b1, 1'b1);
        void'(count_token());
    endfunction

    function automatic void raise_error();
        add_beat(STATUS_TYPE, 1'b0, 8'd0, 1'b0, 1'b0);
        if (item_count > 0) item_beats[item_count - 1].error_flag = 1'b1;
        scan_mode = onl_pkg::MODE_ERROR;
    endfunction

    // A byte seen between tokens; anything not listed here is skipped silently.
    function automatic void start_token(input logic [7:0] c);
        if (c == onl_pkg::CH_DOT) emit_punct(onl_pkg::TT_DOT, c);
        else if (c == onl_pkg::CH_LBRACE) emit_punct(onl_pkg::TT_LBRACE, c);
        else if (c == onl_pkg::CH_RBRACE) emit_punct(onl_pkg::TT_RBRACE, c);
        else if (c == onl_pkg::CH_EQUALS) emit_punct(onl_pkg::TT_EQUALS, c);
        else if (c == onl_pkg::CH_COMMA) emit_punct(onl_pkg::TT_COMMA, c);
        else if (c == onl_pkg::CH_QUOTE) begin
            add_beat(onl_pkg::TT_STRING, 1'b0, 8'd0, 1'b1, 1'b0);
            scan_mode = onl_pkg::MODE_STRING;
        end else if (is_letter(c) || c == onl_pkg::CH_UNDER) begin
            add_beat(onl_pkg::TT_IDENT, 1'b1, c, 1'b1, 1'b0);
            scan_mode = onl_pkg::MODE_IDENT;
        end else if (c == onl_pkg::CH_ZERO) begin
            scan_mode = onl_pkg::MODE_ZERO;
        end else if (c >= CH_ONE && c <= onl_pkg::CH_ZERO + 8'd9) begin
            add_beat(onl_pkg::TT_INT, 1'b1, c, 1'b1, 1'b0);
            scan_mode = onl_pkg::MODE_DEC;
        end else if (c == onl_pkg::CH_SLASH) begin
            scan_mode = onl_pkg::MODE_SLASH;
        end
    endfunction

    function automatic void end_of_text();
        case (scan_mode)
            onl_pkg::MODE_IDLE, onl_pkg::MODE_COMMENT: begin
                add_beat(STATUS_TYPE, 1'b0, 8'd0, 1'b0, 1'b0);
                flag_finished();
                scan_mode = onl_pkg::MODE_DONE;
            end
            onl_pkg::MODE_SLASH, onl_pkg::MODE_ZERO: raise_error();
            onl_pkg::MODE_DONE, onl_pkg::MODE_ERROR: ;
            default: begin
                // An open token, even an unterminated string, is closed and marks the finish.
                void'(close_token(mode_token_type(scan_mode)));
                flag_finished();
                scan_mode = onl_pkg::MODE_DONE;
            end
        endcase
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        onl_pkg::t_mode m;
        logic [3:0]     tt;
        m = scan_mode;
        case (m)
            onl_pkg::MODE_IDLE: start_token(c);
            onl_pkg::MODE_SLASH: begin
                if (c == onl_pkg::CH_SLASH) scan_mode = onl_pkg::MODE_COMMENT;
                else raise_error();
            end
            onl_pkg::MODE_COMMENT: begin
                if (c == onl_pkg::CH_NL) scan_mode = onl_pkg::MODE_IDLE;
            end
            onl_pkg::MODE_STRING: begin
                if (c == onl_pkg::CH_QUOTE) begin
                    void'(close_token(onl_pkg::TT_STRING));
                end else begin
                    add_beat(onl_pkg::TT_STRING, 1'b1, c, 1'b0, 1'b0);
                    if (c == onl_pkg::CH_BSLASH) scan_mode = onl_pkg::MODE_ESCAPE;
                end
            end
            onl_pkg::MODE_ESCAPE: begin
                add_beat(onl_pkg::TT_STRING, 1'b1, c, 1'b0, 1'b0);
                scan_mode = onl_pkg::MODE_STRING;
            end
            onl_pkg::MODE_ZERO: begin
                if (c == onl_pkg::CH_LOW_B || c == onl_pkg::CH_LOW_O || c == onl_pkg::CH_LOW_X)
                begin
                    tt = (c == onl_pkg::CH_LOW_B) ? onl_pkg::TT_BIN
                       : (c == onl_pkg::CH_LOW_O) ? onl_pkg::TT_OCT : onl_pkg::TT_HEX;
                    add_beat(tt, 1'b1, onl_pkg::CH_ZERO, 1'b1, 1'b0);
                    add_beat(tt, 1'b1, c, 1'b0, 1'b0);
                    scan_mode = (c == onl_pkg::CH_LOW_B) ? onl_pkg::MODE_BIN
                              : (c == onl_pkg::CH_LOW_O) ? onl_pkg::MODE_OCT : onl_pkg::MODE_HEX;
                end else begin
                    raise_error();
                end
            end
            onl_pkg::MODE_IDENT, onl_pkg::MODE_BIN, onl_pkg::MODE_OCT, onl_pkg::MODE_HEX,
            onl_pkg::MODE_DEC: begin
                // The byte that ends the token is looked at afresh, unless the limit stopped us.
                if (extends_token(m, c)) add_beat(mode_token_type(m), 1'b1, c, 1'b0, 1'b0);
                else if (!close_token(mode_token_type(m))) start_token(c);
            end
            default: ;
        endcase
    endfunction

    // Predicts the beats of one accepted item and queues them as owed.
    function automatic void tokenize_item(input logic kind, input logic [7:0] c);
        item_count = 0;
        if (kind == KIND_END) end_of_text();
        else scan_byte(c);
        if (item_count > 0) item_beats[item_count - 1].run_last = 1'b1;
        for (int i = 0; i < item_count; i++) beats_due.push_back(item_beats[i]);
    endfunction

    // ------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------

    function automatic void send_byte(input logic [7:0] c);
        text_pending.push_back({KIND_DATA, c});
    endfunction

    // The byte that goes with an end marker is meaningless, so it is random.
    function automatic void send_end();
        text_pending.push_back({KIND_END, 8'($urandom_range(0, 255))});
    endfunction

    function automatic void send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endfunction

    function automatic logic [7:0] pick_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? CH_LOW_A : CH_UP_A;
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_digit(input int top);
        return onl_pkg::CH_ZERO + 8'($urandom_range(0, top));
    endfunction

    function automatic logic [7:0] pick_byte_except(input logic [7:0] avoid);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == avoid);
        return c;
    endfunction

    function automatic logic is_token_start(input logic [7:0] c);
        return c == onl_pkg::CH_DOT || c == onl_pkg::CH_LBRACE || c == onl_pkg::CH_RBRACE
               || c == onl_pkg::CH_EQUALS || c == onl_pkg::CH_COMMA || c == onl_pkg::CH_QUOTE
               || c == onl_pkg::CH_UNDER || c == onl_pkg::CH_SLASH
               || is_letter(c) || is_dec_digit(c);
    endfunction

    function automatic void send_punct();
        case ($urandom_range(0, 4))
            0:       send_byte(onl_pkg::CH_DOT);
            1:       send_byte(onl_pkg::CH_LBRACE);
            2:       send_byte(onl_pkg::CH_RBRACE);
            3:       send_byte(onl_pkg::CH_EQUALS);
            default: send_byte(onl_pkg::CH_COMMA);
        endcase
    endfunction

    // One well-formed token with random content, a comment, skipped noise, or a number whose
    // prefix is followed by a byte that may not belong to it. Only the token limit can stop the lexer here.
    function automatic void send_token();
        int         n;
        logic [7:0] c;
        n = $urandom_range(0, 5);
        case ($urandom_range(0, 9))
            0: send_punct();
            1: begin
                send_byte(onl_pkg::CH_QUOTE);
                repeat (n) begin
                    c = pick_byte_except(onl_pkg::CH_QUOTE);
                    send_byte(c);
                    // A backslash always takes the next byte with it, quote or not.
                    if (c == onl_pkg::CH_BSLASH) send_byte(8'($urandom_range(0, 255)));
                end
                send_byte(onl_pkg::CH_QUOTE);
            end
            2: begin
                send_byte($urandom_range(0, 3) == 0 ? onl_pkg::CH_UNDER : pick_letter());
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0:       send_byte(pick_digit(9));
                        1:       send_byte(onl_pkg::CH_UNDER);
                        default: send_byte(pick_letter());
                    endcase
                end
            end
            3: begin
                send_byte(CH_ONE + 8'($urandom_range(0, 8)));
                repeat (n) send_byte(pick_digit(9));
            end
            4: begin
                send_byte(onl_pkg::CH_ZERO);
                send_byte(onl_pkg::CH_LOW_B);
                repeat (n) send_byte($urandom_range(0, 2) == 0 ? onl_pkg::CH_UNDER : pick_digit(1));
            end
            5: begin
                send_byte(onl_pkg::CH_ZERO);
                send_byte(onl_pkg::CH_LOW_O);
                repeat (n) send_byte(pick_digit(7));
            end
            6: begin
                send_byte(onl_pkg::CH_ZERO);
                send_byte(onl_pkg::CH_LOW_X);
                repeat (n) begin
                    case ($urandom_range(0, 2))
                        0:       send_byte(pick_digit(9));
                        1:       send_byte(CH_LOW_A + 8'($urandom_range(0, 5)));
                        default: send_byte(CH_UP_A + 8'($urandom_range(0, 5)));
                    endcase
                end
            end
            7: begin
                send_byte(onl_pkg::CH_SLASH);
                send_byte(onl_pkg::CH_SLASH);
                repeat (n) send_byte(pick_byte_except(onl_pkg::CH_NL));
                send_byte(onl_pkg::CH_NL);
            end
            8: begin
                repeat (n / 2 + 1) begin
                    do c = 8'($urandom_range(0, 255)); while (is_token_start(c));
                    send_byte(c);
                end
            end
            default: begin
                send_byte(onl_pkg::CH_ZERO);
                case ($urandom_range(0, 2))
                    0:       send_byte(onl_pkg::CH_LOW_B);
                    1:       send_byte(onl_pkg::CH_LOW_O);
                    default: send_byte(onl_pkg::CH_LOW_X);
                endcase
                send_byte($urandom_range(0, 1) ? pick_letter() : pick_digit(9));
            end
        endcase
    endfunction

    function automatic void send_random(input int count);
        int start;
        start = text_pending.size();
        while (text_pending.size() - start < count) send_token();
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task automatic check_beat();
        onl_pkg::t_res got;
        onl_pkg::t_res want;
        got = {o_token_type, o_has_char, o_char_value, o_token_first, o_token_last,
               o_finished, o_error_flag, o_run_last};
        if (beats_due.size() == 0) begin
            report_mismatch($sformatf("beat %h arrived with nothing owed", got));
        end else begin
            want = beats_due.pop_front();
            compare_field("token_type", got.token_type, want.token_type);
            compare_field("has_char", got.has_char, want.has_char);
            compare_field("char_value", got.char_value, want.char_value);
            compare_field("token_first", got.token_first, want.token_first);
            compare_field("token_last", got.token_last, want.token_last);
            compare_field("finished", got.finished, want.finished);
            compare_field("error_flag", got.error_flag, want.error_flag);
            compare_field("run_last", got.run_last, want.run_last);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: pushes pending text, with random bursts of idle cycles.
    // The item on the ports at an edge with push high and full low is accepted, and the
    // predictor sees it right there, before the next item replaces it.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!(push && full)) begin
            if (push) tokenize_item(i_kind, i_byte_value);
            if (send_gap > 0) begin
                send_gap--;
                push <= 1'b0;
            end else if (idle_odds != 0 && text_pending.size() != 0
                         && $urandom_range(1, idle_odds) == 1) begin
                send_gap = $urandom_range(0, 12);
                push <= 1'b0;
            end else if (text_pending.size() != 0) begin
                next_item = text_pending.pop_front();
                i_kind       <= next_item.kind;
                i_byte_value <= next_item.value;
                push         <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: pops result beats, stalling in random bursts, and checks each accepted beat
    // against the oldest one owed.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) check_beat();
            if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                pop_gap = $urandom_range(0, 12);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("object_notation_tokenizer_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------

    // Holds the sender until every pushed item is in and every owed beat is out. Items that
    // cause no beat may still be in flight, so a settle wait follows before returning.
    task automatic wait_drained();
        @(negedge i_clk);
        while (text_pending.size() != 0 || push || beats_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write of token_limit (setup, then access), then a read back of the same register.
    task automatic write_limit(input logic [15:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= LIMIT_ADDR;
        pwdata  <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // The register takes the value at this edge.
        limit_copy = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata[15:0] !== value)
            report_mismatch($sformatf("token_limit reads %h, written %h", prdata[15:0], value));
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        t_ending    ending;
        logic [7:0] c;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed text: all punctuation, a string holding an escaped quote and a zero byte,
        // a comment holding an all-ones byte, an octal number ended by a non-octal digit,
        // and a hex number ended by an underscore that starts an identifier.
        write_limit(onl_pkg::COUNT_MAX);
        idle_odds = 4;
        send_text(".{}=,");
        send_text("\"\\\"");
        send_byte(8'h00);
        send_byte(onl_pkg::CH_QUOTE);
        send_text("//");
        send_byte(8'hFF);
        send_byte(onl_pkg::CH_NL);
        send_text("0o78=");
        send_text("0xaF_ ");
        wait_drained();

        // Random token streams under a few limit settings; a phase may begin with a token left open.
        write_limit(16'($urandom_range(1000, 60000)));
        idle_odds = 3;
        send_random(25);
        wait_drained();

        write_limit(onl_pkg::COUNT_MAX);
        idle_odds = 8;
        send_random(25);
        wait_drained();

        // Last stretch runs flat out on both sides.
        idle_odds = 0;
        send_random(25);

        // The lexer stops only once until reset, so each run picks one way to stop it.
        ending = t_ending'($urandom_range(0, 5));
        // A space closes any identifier or number still open.
        send_byte(CH_SPACE);
        case (ending)
            END_IDLE: begin
                send_punct();
                send_end();
            end
            END_COMMENT: begin
                send_text("//");
                repeat ($urandom_range(0, 3)) send_byte(pick_byte_except(onl_pkg::CH_NL));
                send_end();
            end
            END_IN_TOKEN: begin
                case ($urandom_range(0, 2))
                    0: begin
                        send_byte(onl_pkg::CH_QUOTE);
                        send_byte(pick_byte_except(onl_pkg::CH_QUOTE));
                    end
                    1:       send_byte(pick_letter());
                    default: send_text("0x");
                endcase
                send_end();
            end
            END_SLASH: begin
                send_byte(onl_pkg::CH_SLASH);
                if ($urandom_range(0, 1)) send_end();
                else send_byte(pick_byte_except(onl_pkg::CH_SLASH));
            end
            END_ZERO: begin
                send_byte(onl_pkg::CH_ZERO);
                if ($urandom_range(0, 1)) begin
                    send_end();
                end else begin
                    do c = 8'($urandom_range(0, 255));
                    while (c == onl_pkg::CH_LOW_B || c == onl_pkg::CH_LOW_O
                           || c == onl_pkg::CH_LOW_X);
                    send_byte(c);
                end
            end
            default: begin
                // Limit below the count, zero, or just above the count.
                wait_drained();
                case ($urandom_range(0, 2))
                    0:       write_limit(16'd1);
                    1:       write_limit(16'd0);
                    default: write_limit(token_total + 16'($urandom_range(1, 3)));
                endcase
                repeat (12) send_token();
            end
        endcase

        // Once stopped, anything pushed must be swallowed without a beat.
        repeat (5) text_pending.push_back({1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))});
        wait_drained();
        write_limit(16'd1);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("object_notation_tokenizer_unit test passed");
        end else begin
            $display("object_notation_tokenizer_unit test failed");
        end
        $finish;
    end

endmodule
